// ===== design/xmodem_checksum_receiver_macros.svh =====
// assertion macros used by the checker file of the xmodem checksum receiver
`ifndef XMODEM_CHECKSUM_RECEIVER_MACROS_SVH
`define XMODEM_CHECKSUM_RECEIVER_MACROS_SVH

// consequent must hold in the clock after the antecedent
`define XCR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// consequent must hold in the same clock as the antecedent
`define XCR_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== design/xcr_pkg.sv =====
// package with types, codes and helpers of the xmodem checksum receiver
package xcr_pkg;

   localparam int PACKET_BYTES_DEF = 128;

   localparam logic [31:0] BASE_ADDRESS_RESET = 32'h0000_0000;
   localparam logic [7:0]  ERR_LIMIT_RESET    = 8'd5;

   // control characters
   localparam logic [7:0] CH_SOH    = 8'h01;
   localparam logic [7:0] CH_EOT    = 8'h04;
   localparam logic [7:0] CH_ACK    = 8'h06;
   localparam logic [7:0] CH_NAK    = 8'h15;
   localparam logic [7:0] CH_CAN    = 8'h18;
   localparam logic [7:0] BYTE_MASK = 8'hFF;

   // transaction commands
   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_BYTE    = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;
   localparam logic [1:0] CMD_STATUS  = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_REPLY = 2'd0;
   localparam logic [1:0] KIND_ERASE = 2'd1;
   localparam logic [1:0] KIND_WORD  = 2'd2;

   // session status
   localparam logic [1:0] SESS_RUN   = 2'd0;
   localparam logic [1:0] SESS_DONE  = 2'd1;
   localparam logic [1:0] SESS_ABORT = 2'd2;

   // register indexes
   localparam logic CSR_BASE_ADDRESS = 1'b0;
   localparam logic CSR_ERR_LIMIT    = 1'b1;

   // error counter saturation value
   localparam logic [8:0] ERR_SAT = 9'd511;

   typedef struct packed {
      logic [31:0] base_address;
      logic [7:0]  err_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  reply_byte;
      logic [31:0] address;
      logic [31:0] data_word;
      logic        last;
      logic [1:0]  session;
   } rsp_type;

   // reply byte result, always the final one of its transaction
   function automatic rsp_type mk_reply(input logic [7:0] code, input logic [1:0] sess);
      rsp_type r;
      r            = '0;
      r.kind       = KIND_REPLY;
      r.reply_byte = code;
      r.last       = 1'b1;
      r.session    = sess;
      return r;
   endfunction

endpackage

// ===== design/xmodem_checksum_receiver.sv =====
// top level of the xmodem checksum receiver
//
// Usage: every event of the serial link is one transaction on the req_
// channel (start, received byte, timeout, flash write status). Results leave
// on the rsp_ channel: reply bytes for the sender, an erase request and the
// word writes of a good packet; rsp_last marks the final result of each
// transaction. csr_ writes set the base address and the error limit.
// A reply is registered in the result queue when its transaction is taken.
// Throughput: transactions that give at most one result are taken one per
// cycle while the result queue is not full. The sum byte of a matching
// packet starts a burst of PACKET_BYTES/4 word writes (plus an erase for
// packet one), one per cycle, read from the packet buffer one word ahead;
// req_ready stays low and no transaction is taken until the burst ends.
// Reset: the session goes idle, the registers return to their defaults and
// the two-entry result queue empties; the buffer keeps its contents.
// Stall: when the receiver of rsp_ holds ready low, up to two results wait
// in the queue; req_ready drops once it is full and the burst pauses.
module xmodem_checksum_receiver import xcr_pkg::*; #(
   parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_write_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_reply_byte,
   output logic [31:0] rsp_address,
   output logic [31:0] rsp_data_word,
   output logic        rsp_last,
   output logic [1:0]  rsp_session,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int WORDS = PACKET_BYTES / 4;
   localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   cfg_type          cfg_ff;
   rsp_type          q_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;
   logic             q_full;
   logic             push;
   logic             pop;
   rsp_type          push_data;
   rsp_type          head;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [31:0]      mem_wr_data;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [31:0]      mem_rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address <= BASE_ADDRESS_RESET;
         cfg_ff.err_limit    <= ERR_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE_ADDRESS: cfg_ff.base_address <= csr_wdata;
            CSR_ERR_LIMIT:    cfg_ff.err_limit    <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   xcr_ctrl #(
      .PACKET_BYTES(PACKET_BYTES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_rx_byte (req_rx_byte),
      .req_write_ok(req_write_ok),
      .q_full      (q_full),
      .push        (push),
      .push_data   (push_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   xcr_buf #(
      .WORDS(WORDS)
   ) u_buf (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   // two-entry result queue
   assign q_full    = cnt_ff == 2'd2;
   assign rsp_valid = cnt_ff != 2'd0;
   assign pop       = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= push_data;
      end
   end

   // head of the queue drives the result transaction
   assign head           = q_ff[rp_ff];
   assign rsp_kind       = head.kind;
   assign rsp_reply_byte = head.reply_byte;
   assign rsp_address    = head.address;
   assign rsp_data_word  = head.data_word;
   assign rsp_last       = head.last;
   assign rsp_session    = head.session;

endmodule

// ===== design/xcr_buf.sv =====
// packet buffer: word memory, one write and one registered read per cycle
module xcr_buf import xcr_pkg::*; #(
   parameter int WORDS = PACKET_BYTES_DEF / 4,
   localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [31:0]      wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [31:0]      rd_data
);

   logic [31:0] mem [WORDS];
   logic [31:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/xcr_ctrl.sv =====
// frame decoder, session state and result sequencer of the receiver
module xcr_ctrl import xcr_pkg::*; #(
   parameter int PACKET_BYTES = PACKET_BYTES_DEF,
   localparam int WORDS  = PACKET_BYTES / 4,
   localparam int IDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1,
   localparam int BIDX_W = $clog2(PACKET_BYTES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_command,
   input  logic [7:0]       req_rx_byte,
   input  logic             req_write_ok,
   input  logic             q_full,
   output logic             push,
   output rsp_type          push_data,
   output logic             mem_wr_en,
   output logic [IDX_W-1:0] mem_wr_addr,
   output logic [31:0]      mem_wr_data,
   output logic [IDX_W-1:0] mem_rd_addr,
   input  logic [31:0]      mem_rd_data
);

   typedef enum logic [6:0] {
      PH_IDLE   = 7'b000_0001,
      PH_HEADER = 7'b000_0010,
      PH_NUMBER = 7'b000_0100,
      PH_COMPL  = 7'b000_1000,
      PH_DATA   = 7'b001_0000,
      PH_SUM    = 7'b010_0000,
      PH_WRITE  = 7'b100_0000
   } phase_type;

   typedef enum logic [2:0] {
      SEQ_RUN   = 3'b001,
      SEQ_ERASE = 3'b010,
      SEQ_WORDS = 3'b100
   } seq_type;

   phase_type         phase_ff, phase_in;
   seq_type           seq_ff, seq_in;
   logic [BIDX_W-1:0] bidx_ff, bidx_in;
   logic [7:0]        exp_ff, exp_in;
   logic [7:0]        num_ff, num_in;
   logic [7:0]        cmp_ff, cmp_in;
   logic [7:0]        sum_ff, sum_in;
   logic [8:0]        err_ff, err_in;
   logic [31:0]       waddr_ff, waddr_in;
   logic [31:0]       curaddr_ff, curaddr_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [23:0]       pack_ff, pack_in;

   logic              accept;
   logic [8:0]        err_inc;
   logic              over;
   phase_type         fail_phase;
   rsp_type           fail_res;
   logic              frame_ok;
   logic              last_word;

   assign req_ready = (seq_ff == SEQ_RUN) && !q_full;
   assign accept    = req_valid && req_ready;

   // error counting shared by the header, sum and timeout failure paths
   assign err_inc    = (err_ff == ERR_SAT) ? err_ff : err_ff + 9'd1;
   assign over       = err_inc > {1'b0, cfg.err_limit};
   assign fail_phase = over ? PH_IDLE : PH_HEADER;
   assign fail_res   = over ? mk_reply(CH_CAN, SESS_ABORT) : mk_reply(CH_NAK, SESS_RUN);

   assign frame_ok  = (num_ff == (cmp_ff ^ BYTE_MASK)) && (sum_ff == req_rx_byte);
   assign last_word = idx_ff == IDX_W'(WORDS - 1);

   // buffer writes happen only in the data phase and read data is used only in
   // the burst, so no write can overlap a read whose data is used
   assign mem_wr_addr = bidx_ff[IDX_W+1:2];
   assign mem_wr_data = {req_rx_byte, pack_ff};
   assign mem_rd_addr = idx_in;

   // next state and result selection
   always_comb begin
      phase_in   = phase_ff;
      seq_in     = seq_ff;
      bidx_in    = bidx_ff;
      exp_in     = exp_ff;
      num_in     = num_ff;
      cmp_in     = cmp_ff;
      sum_in     = sum_ff;
      err_in     = err_ff;
      waddr_in   = waddr_ff;
      curaddr_in = curaddr_ff;
      idx_in     = '0;
      pack_in    = pack_ff;
      push       = 1'b0;
      push_data  = '0;
      mem_wr_en  = 1'b0;

      case (seq_ff)
         SEQ_RUN: begin
            if (accept) begin
               case (req_command)
                  CMD_START: begin
                     phase_in  = PH_HEADER;
                     bidx_in   = '0;
                     exp_in    = 8'd1;
                     num_in    = '0;
                     cmp_in    = '0;
                     sum_in    = '0;
                     err_in    = '0;
                     waddr_in  = cfg.base_address;
                     push      = 1'b1;
                     push_data = mk_reply(CH_NAK, SESS_RUN);
                  end
                  CMD_BYTE: begin
                     case (phase_ff)
                        PH_HEADER: begin
                           if (req_rx_byte == CH_SOH) begin
                              phase_in = PH_NUMBER;
                              bidx_in  = '0;
                              sum_in   = '0;
                           end else if (req_rx_byte == CH_EOT) begin
                              err_in    = '0;
                              phase_in  = PH_IDLE;
                              push      = 1'b1;
                              push_data = mk_reply(CH_ACK, SESS_DONE);
                           end else begin
                              err_in    = err_inc;
                              phase_in  = fail_phase;
                              push      = 1'b1;
                              push_data = fail_res;
                           end
                        end
                        PH_NUMBER: begin
                           num_in   = req_rx_byte;
                           phase_in = PH_COMPL;
                        end
                        PH_COMPL: begin
                           cmp_in   = req_rx_byte;
                           phase_in = PH_DATA;
                           bidx_in  = '0;
                        end
                        PH_DATA: begin
                           // gather bytes and store each completed word
                           pack_in   = {req_rx_byte, pack_ff[23:8]};
                           mem_wr_en = bidx_ff[1:0] == 2'b11;
                           sum_in    = sum_ff + req_rx_byte;
                           bidx_in   = bidx_ff + 1'b1;
                           if (bidx_ff == BIDX_W'(PACKET_BYTES - 1)) begin
                              phase_in = PH_SUM;
                           end
                        end
                        PH_SUM: begin
                           if (!frame_ok) begin
                              err_in    = err_inc;
                              phase_in  = fail_phase;
                              push      = 1'b1;
                              push_data = fail_res;
                           end else if (num_ff != exp_ff) begin
                              err_in    = '0;
                              phase_in  = PH_HEADER;
                              push      = 1'b1;
                              push_data = mk_reply(CH_NAK, SESS_RUN);
                           end else begin
                              err_in     = '0;
                              phase_in   = PH_WRITE;
                              curaddr_in = waddr_ff;
                              seq_in     = (exp_ff == 8'd1) ? SEQ_ERASE : SEQ_WORDS;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
                  CMD_TIMEOUT: begin
                     case (phase_ff)
                        PH_HEADER, PH_NUMBER, PH_COMPL, PH_DATA, PH_SUM: begin
                           err_in    = err_inc;
                           phase_in  = fail_phase;
                           push      = 1'b1;
                           push_data = fail_res;
                        end
                        default: begin
                        end
                     endcase
                  end
                  CMD_STATUS: begin
                     if (phase_ff == PH_WRITE) begin
                        exp_in   = exp_ff + 8'd1;
                        phase_in = PH_HEADER;
                        push     = 1'b1;
                        if (req_write_ok) begin
                           waddr_in  = waddr_ff + 32'(PACKET_BYTES);
                           push_data = mk_reply(CH_ACK, SESS_RUN);
                        end else begin
                           push_data = mk_reply(CH_CAN, SESS_RUN);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         SEQ_ERASE: begin
            // erase request ahead of the first packet's words
            if (!q_full) begin
               push              = 1'b1;
               push_data.kind    = KIND_ERASE;
               push_data.address = cfg.base_address;
               seq_in            = SEQ_WORDS;
            end
         end
         SEQ_WORDS: begin
            // one word a cycle while the queue is not full; the read address runs one word ahead
            idx_in = idx_ff;
            if (!q_full) begin
               push                = 1'b1;
               push_data.kind      = KIND_WORD;
               push_data.address   = curaddr_ff;
               push_data.data_word = mem_rd_data;
               push_data.last      = last_word;
               curaddr_in          = curaddr_ff + 32'd4;
               idx_in              = idx_ff + 1'b1;
               if (last_word) begin
                  seq_in = SEQ_RUN;
                  idx_in = '0;
               end
            end
         end
         default: begin
            seq_in = SEQ_RUN;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         seq_ff   <= SEQ_RUN;
         bidx_ff  <= '0;
         exp_ff   <= 8'd1;
         num_ff   <= '0;
         cmp_ff   <= '0;
         sum_ff   <= '0;
         err_ff   <= '0;
         waddr_ff <= '0;
         idx_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         seq_ff   <= seq_in;
         bidx_ff  <= bidx_in;
         exp_ff   <= exp_in;
         num_ff   <= num_in;
         cmp_ff   <= cmp_in;
         sum_ff   <= sum_in;
         err_ff   <= err_in;
         waddr_ff <= waddr_in;
         idx_ff   <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      curaddr_ff <= curaddr_in;
      pack_ff    <= pack_in;
   end

endmodule

// ===== design/xcr_checker.sv =====
// port checker of the xmodem checksum receiver and its bind
`include "xmodem_checksum_receiver_macros.svh"

module xcr_checker import xcr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_address,
   input logic [31:0] rsp_data_word,
   input logic        rsp_last
);

   // a stalled result holds
   `XCR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_address) && $stable(rsp_data_word), "stalled result changed")

   // reset empties the result queue
   `XCR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result pending after reset")

   // an erase is directly followed by the first word
   `XCR_ASSERT_NEXT(a_erase_word, clock, reset, rsp_valid && rsp_ready && rsp_kind == KIND_ERASE, rsp_valid && rsp_kind == KIND_WORD, "erase not followed by a word")

   // words of a burst follow back to back at rising addresses
   `XCR_ASSERT_NEXT(a_word_step, clock, reset, rsp_valid && rsp_ready && rsp_kind == KIND_WORD && !rsp_last, rsp_valid && rsp_kind == KIND_WORD && rsp_address == $past(rsp_address) + 32'd4, "word burst broken")

   // no transaction is taken while a burst is under way
   `XCR_ASSERT_NOW(a_burst_block, clock, reset, rsp_valid && rsp_kind == KIND_WORD && !rsp_last, !req_ready, "input taken during a burst")

endmodule

bind xmodem_checksum_receiver xcr_checker u_xcr_checker (.*);

// ===== bench/xmodem_checksum_receiver_tb.sv =====
// self-checking testbench of the xmodem checksum receiver with a built-in predictor
module xmodem_checksum_receiver_tb;
   import xcr_pkg::*;

   localparam int PACKET_BYTES = PACKET_BYTES_DEF;
   localparam int WORDS = PACKET_BYTES / 4;
   localparam int DRAIN_CYCLES = WORDS + 8;
   localparam int HOLD_CYCLES = 400;
   localparam int RUN_LIMIT = 1000000;
   localparam int MAX_REPORTS = 50;

   typedef enum logic [6:0] {
      RX_IDLE   = 7'b000_0001,
      RX_HEADER = 7'b000_0010,
      RX_NUMBER = 7'b000_0100,
      RX_COMPL  = 7'b000_1000,
      RX_DATA   = 7'b001_0000,
      RX_SUM    = 7'b010_0000,
      RX_WRITE  = 7'b100_0000
   } rx_phase_type;

   typedef enum {FRAME_GOOD, FRAME_BAD_COMPL, FRAME_BAD_SUM, FRAME_SHORT} frame_flaw_type;
   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} frame_fill_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] rx_byte;
      logic       write_ok;
   } link_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_START;
   logic [7:0]  req_rx_byte = '0;
   logic        req_write_ok = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_reply_byte;
   logic [31:0] rsp_address;
   logic [31:0] rsp_data_word;
   logic        rsp_last;
   logic [1:0]  rsp_session;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = CSR_BASE_ADDRESS;
   logic [31:0] csr_wdata = '0;

   // stimulus queue and expected results
   link_event_type link_events[$];
   rsp_type        due_results[$];
   rsp_type        step_results[$];

   // idling control
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   bit          hold_request = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;

   int unsigned failures = 0;
   int unsigned cycle_count = 0;

   // predictor state and register copies
   logic [31:0]  cfg_base = BASE_ADDRESS_RESET;
   logic [7:0]   cfg_err_limit = ERR_LIMIT_RESET;
   rx_phase_type rx_phase = RX_IDLE;
   int unsigned  byte_index = 0;
   logic [7:0]   exp_number = 8'd1;
   logic [7:0]   got_number = '0;
   logic [7:0]   got_compl = '0;
   logic [7:0]   running_sum = '0;
   logic [8:0]   err_count = '0;
   logic [31:0]  write_addr = '0;
   logic [7:0]   pkt_buf [PACKET_BYTES];

   xmodem_checksum_receiver #(.PACKET_BYTES(PACKET_BYTES)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_rx_byte    (req_rx_byte),
      .req_write_ok   (req_write_ok),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_reply_byte (rsp_reply_byte),
      .rsp_address    (rsp_address),
      .rsp_data_word  (rsp_data_word),
      .rsp_last       (rsp_last),
      .rsp_session    (rsp_session),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ---------------------------------------------------------------- predictor

   function automatic rsp_type reply_result(input logic [7:0] code, input logic [1:0] sess);
      rsp_type r;
      r = '0;
      r.kind = KIND_REPLY;
      r.reply_byte = code;
      r.session = sess;
      return r;
   endfunction

   function automatic rsp_type flash_result(input logic [1:0] kind, input logic [31:0] addr,
                                            input logic [31:0] word);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.address = addr;
      r.data_word = word;
      r.session = SESS_RUN;
      return r;
   endfunction

   // error path: NAK and wait for a header, or CAN once the limit is passed
   function automatic void count_frame_error();
      if (err_count < ERR_SAT) err_count++;
      if (err_count > {1'b0, cfg_err_limit}) begin
         rx_phase = RX_IDLE;
         step_results.push_back(reply_result(CH_CAN, SESS_ABORT));
      end else begin
         rx_phase = RX_HEADER;
         step_results.push_back(reply_result(CH_NAK, SESS_RUN));
      end
   endfunction

   // update the receiver state for one accepted transaction, queue its results
   function automatic void apply_link_event(input logic [1:0] cmd, input logic [7:0] b,
                                            input logic ok);
      logic [31:0] word;
      step_results.delete();
      case (cmd)
         CMD_START: begin
            rx_phase = RX_HEADER;
            byte_index = 0;
            exp_number = 8'd1;
            got_number = '0;
            got_compl = '0;
            running_sum = '0;
            err_count = '0;
            write_addr = cfg_base;
            step_results.push_back(reply_result(CH_NAK, SESS_RUN));
         end
         CMD_BYTE: begin
            case (rx_phase)
               RX_HEADER: begin
                  if (b == CH_SOH) begin
                     rx_phase = RX_NUMBER;
                     byte_index = 0;
                     running_sum = '0;
                  end else if (b == CH_EOT) begin
                     err_count = '0;
                     rx_phase = RX_IDLE;
                     step_results.push_back(reply_result(CH_ACK, SESS_DONE));
                  end else begin
                     count_frame_error();
                  end
               end
               RX_NUMBER: begin
                  got_number = b;
                  rx_phase = RX_COMPL;
               end
               RX_COMPL: begin
                  got_compl = b;
                  rx_phase = RX_DATA;
                  byte_index = 0;
               end
               RX_DATA: begin
                  if (byte_index < PACKET_BYTES) pkt_buf[byte_index] = b;
                  running_sum = running_sum + b;
                  byte_index++;
                  if (byte_index >= PACKET_BYTES) rx_phase = RX_SUM;
               end
               RX_SUM: begin
                  // frame complete: check complement and sum, then the number
                  if (got_number != (got_compl ^ BYTE_MASK) || running_sum != b) begin
                     count_frame_error();
                  end else begin
                     err_count = '0;
                     if (got_number != exp_number) begin
                        rx_phase = RX_HEADER;
                        step_results.push_back(reply_result(CH_NAK, SESS_RUN));
                     end else begin
                        if (exp_number == 8'd1)
                           step_results.push_back(flash_result(KIND_ERASE, cfg_base, '0));
                        for (int i = 0; i < WORDS; i++) begin
                           word = {pkt_buf[4*i+3], pkt_buf[4*i+2], pkt_buf[4*i+1], pkt_buf[4*i]};
                           step_results.push_back(
                              flash_result(KIND_WORD, write_addr + 32'(4 * i), word));
                        end
                        rx_phase = RX_WRITE;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         CMD_TIMEOUT: begin
            if (rx_phase >= RX_HEADER && rx_phase <= RX_SUM) count_frame_error();
         end
         default: begin
            // write status only matters while one is awaited
            if (rx_phase == RX_WRITE) begin
               exp_number = exp_number + 8'd1;
               rx_phase = RX_HEADER;
               if (ok) begin
                  write_addr = write_addr + 32'(PACKET_BYTES);
                  step_results.push_back(reply_result(CH_ACK, SESS_RUN));
               end else begin
                  step_results.push_back(reply_result(CH_CAN, SESS_RUN));
               end
            end
         end
      endcase
      if (step_results.size() != 0) step_results[$].last = 1'b1;
      foreach (step_results[i]) due_results.push_back(step_results[i]);
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : drive_proc
      link_event_type ev;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) apply_link_event(req_command, req_rx_byte, req_write_ok);
         if (req_valid && !req_ready) begin
            // hold the offered transaction
         end else if (link_events.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            ev = link_events.pop_front();
            req_valid <= 1'b1;
            req_command <= ev.command;
            req_rx_byte <= ev.rx_byte;
            req_write_ok <= ev.write_ok;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_proc
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $error("result with nothing expected: kind %0d reply 0x%0h address 0x%0h",
                         rsp_kind, rsp_reply_byte, rsp_address);
            end else begin
               want = due_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("reply_byte", 32'(want.reply_byte), 32'(rsp_reply_byte));
               check_field("address", want.address, rsp_address);
               check_field("data_word", want.data_word, rsp_data_word);
               check_field("last", 32'(want.last), 32'(rsp_last));
               check_field("session", 32'(want.session), 32'(rsp_session));
            end
         end
      end
   end

   // long receiver hold-off so the result queue fills and req_ready drops
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_event(input logic [1:0] cmd, input logic [7:0] b, input logic ok);
      link_event_type ev;
      ev.command = cmd;
      ev.rx_byte = b;
      ev.write_ok = ok;
      link_events.push_back(ev);
   endtask

   // one sender frame, optionally damaged or cut short
   task automatic push_frame(input logic [7:0] number, input frame_flaw_type flaw,
                             input frame_fill_type fill);
      logic [7:0] sum;
      logic [7:0] compl;
      logic [7:0] data;
      int         n;
      sum = '0;
      compl = ~number;
      if (flaw == FRAME_BAD_COMPL) compl = compl ^ 8'($urandom_range(1, 255));
      push_event(CMD_BYTE, CH_SOH, 1'($urandom));
      push_event(CMD_BYTE, number, 1'($urandom));
      push_event(CMD_BYTE, compl, 1'($urandom));
      n = (flaw == FRAME_SHORT) ? int'($urandom_range(0, PACKET_BYTES - 1)) : PACKET_BYTES;
      for (int i = 0; i < n; i++) begin
         case (fill)
            FILL_ZERO: data = 8'h00;
            FILL_ONES: data = 8'hFF;
            default:   data = 8'($urandom);
         endcase
         sum = sum + data;
         push_event(CMD_BYTE, data, 1'($urandom));
      end
      if (flaw != FRAME_SHORT) begin
         if (flaw == FRAME_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
         push_event(CMD_BYTE, sum, 1'($urandom));
      end
   endtask

   // all transactions accepted and every result back, then let the block settle
   task automatic wait_quiet();
      do @(posedge clock);
      while (link_events.size() != 0 || req_valid || due_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_BASE_ADDRESS) cfg_base = value;
      else cfg_err_limit = value[7:0];
   endtask

   task automatic setup_phase(input logic [31:0] base, input logic [7:0] err_limit,
                              input int unsigned idle_pct, input int unsigned stall_pct);
      wait_quiet();
      write_csr(CSR_BASE_ADDRESS, base);
      write_csr(CSR_ERR_LIMIT, {24'd0, err_limit});
      @(negedge clock);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default registers, no idling, receiver holds off at the start so the result queue fills
      hold_request = 1'b1;
      push_event(CMD_BYTE, CH_SOH, 1'b1);
      push_event(CMD_TIMEOUT, 8'hFF, 1'b0);
      push_event(CMD_STATUS, 8'h00, 1'b1);
      push_event(CMD_START, 8'h00, 1'b0);
      push_event(CMD_BYTE, 8'h00, 1'b0);
      push_event(CMD_TIMEOUT, 8'h00, 1'b0);
      push_frame(8'd1, FRAME_GOOD, FILL_ONES);
      push_event(CMD_BYTE, CH_SOH, 1'b0);
      push_event(CMD_STATUS, 8'h00, 1'b1);
      push_event(CMD_BYTE, CH_EOT, 1'b0);

      // zero error limit, slow sender: the first failure aborts
      setup_phase(32'h0000_0000, 8'd0, 82, 0);
      push_event(CMD_START, 8'h00, 1'b0);
      push_event(CMD_TIMEOUT, 8'h00, 1'b0);
      push_event(CMD_START, 8'h00, 1'b0);
      push_event(CMD_BYTE, CH_SOH, 1'b0);
      push_event(CMD_BYTE, 8'd1, 1'b0);
      push_event(CMD_BYTE, 8'hFE, 1'b0);
      push_event(CMD_TIMEOUT, 8'h00, 1'b0);
      push_event(CMD_START, 8'h00, 1'b0);
      push_event(CMD_BYTE, CH_EOT, 1'b0);
      push_event(CMD_STATUS, 8'h00, 1'b1);

      // slow receiver, word addresses wrap past the top, write failure
      setup_phase(32'hFFFF_FFC0, 8'd1, 0, 82);
      push_event(CMD_START, 8'h00, 1'b0);
      push_frame(8'd1, FRAME_GOOD, FILL_RANDOM);
      push_event(CMD_TIMEOUT, 8'h00, 1'b0);
      push_event(CMD_STATUS, 8'h00, 1'b0);
      push_event(CMD_TIMEOUT, 8'h00, 1'b0);
      push_event(CMD_BYTE, 8'h7F, 1'b0);

      // light idling on both sides, restart inside a frame, abort by timeouts
      setup_phase(32'($urandom), 8'd3, 7, 7);
      push_event(CMD_START, 8'h00, 1'b0);
      push_event(CMD_BYTE, CH_SOH, 1'b0);
      push_event(CMD_BYTE, 8'd1, 1'b0);
      push_event(CMD_START, 8'h00, 1'b0);
      push_event(CMD_BYTE, CH_EOT, 1'b0);
      push_event(CMD_START, 8'h00, 1'b0);
      repeat (4) push_event(CMD_TIMEOUT, 8'($urandom), 1'($urandom));
      push_event(CMD_BYTE, CH_SOH, 1'b0);
      push_event(CMD_STATUS, 8'h00, 1'b1);

      wait_quiet();
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== xmodem_checksum_receiver.f =====
+incdir+design
design/xcr_pkg.sv
design/xcr_buf.sv
design/xcr_ctrl.sv
design/xmodem_checksum_receiver.sv
design/xcr_checker.sv
bench/xmodem_checksum_receiver_tb.sv
